[sv/thwa_pkg.sv]
// shared types and constants for the temperature / humidity block averager
// no dependencies; used by the channel, the divider and the top level
package thwa_pkg;

  // both channels are carried as 17-bit signed values inside the block
  localparam int unsigned CH_W = 17;

  typedef logic signed [CH_W-1:0] chval_t;

  // configuration register index
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TEMP_MIN = 2'd0;
  localparam cfg_idx_t CFG_TEMP_MAX = 2'd1;
  localparam cfg_idx_t CFG_HUMI_MIN = 2'd2;
  localparam cfg_idx_t CFG_HUMI_MAX = 2'd3;

  // valid range of one channel
  typedef struct packed {
    chval_t lo;
    chval_t hi;
  } bounds_t;

  // per-item result of one channel
  typedef struct packed {
    chval_t avg;
    logic   fault;
  } chan_res_t;

endpackage

[sv/thwa_ifs.sv]
// valid/ready channel interfaces for the tick input and the result output
// depends on nothing but the field widths of the block
interface thwa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_reading;
  logic        [15:0] humi_reading;
  logic               link_online;

  modport source(output valid, temp_reading, humi_reading, link_online, input ready);
  modport sink(input valid, temp_reading, humi_reading, link_online, output ready);
endinterface

interface thwa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] avg_temp;
  logic               temp_fault;
  logic        [15:0] avg_humi;
  logic               humi_fault;

  modport source(output valid, avg_temp, temp_fault, avg_humi, humi_fault, input ready);
  modport sink(input valid, avg_temp, temp_fault, avg_humi, humi_fault, output ready);
endinterface

[sv/thwa_div.sv]
// divides a ring sum by the sample count, truncating toward zero
// uses a reciprocal multiply; depends on thwa_pkg
module thwa_div #(
  parameter int unsigned N  = 8,
  parameter int unsigned MW = 19
) (
  input  logic signed [MW:0] dividend,
  output thwa_pkg::chval_t   quotient
);

  localparam int unsigned L     = $clog2(N);
  localparam int unsigned K     = MW + L;
  localparam int unsigned MUL_W = 2 * MW + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'(N) - 64'd1) / 64'(N);
  localparam logic [MW:0] RECIP = RECIP_L[MW:0];

  logic              neg;
  logic [MW:0]       neg_val;
  logic [MW-1:0]     mag;
  logic [MUL_W-1:0]  prod;
  thwa_pkg::chval_t  q_mag;

  // magnitude of the sum
  assign neg     = dividend[MW];
  assign neg_val = -dividend;
  assign mag     = neg ? neg_val[MW-1:0] : dividend[MW-1:0];

  // floor(mag / N) exactly for any mag below 2**MW
  assign prod  = MUL_W'(mag) * MUL_W'(RECIP);
  assign q_mag = prod[K +: thwa_pkg::CH_W];

  // restore the sign
  assign quotient = neg ? -q_mag : q_mag;

endmodule

[sv/thwa_chan.sv]
// one channel: sample ring memory with running sum, fill index and stored average
// depends on thwa_pkg and thwa_div
module thwa_chan #(
  parameter int unsigned SAMPLE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  thwa_pkg::bounds_t   bounds,
  input  thwa_pkg::chval_t    reading,
  input  logic                online,
  input  logic                strict_gate,
  output thwa_pkg::chan_res_t res
);

  localparam int unsigned L  = $clog2(SAMPLE_COUNT);
  localparam int unsigned AW = (SAMPLE_COUNT > 1) ? L : 1;
  localparam int unsigned IW = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned SW = thwa_pkg::CH_W + L;
  localparam logic [IW-1:0] FULL = IW'(SAMPLE_COUNT);

  thwa_pkg::chval_t ring_r [SAMPLE_COUNT];
  thwa_pkg::chval_t rd_data_r;
  thwa_pkg::chval_t fwd_r;
  logic             hit_r;
  logic [SAMPLE_COUNT-1:0] vld_r;

  logic [IW-1:0]         idx_r, idx_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  thwa_pkg::chval_t      avg_r, avg_nxt;

  logic             fault;
  logic             not_full;
  logic             in_rng;
  logic             take;
  logic             we;
  thwa_pkg::chval_t samp;
  thwa_pkg::chval_t avg_eff;
  thwa_pkg::chval_t old;
  thwa_pkg::chval_t quot;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    raddr;
  logic [IW-1:0]    ra_idx;

  // average of the full ring
  thwa_div #(
    .N  (SAMPLE_COUNT),
    .MW (SW - 1)
  ) u_div (
    .dividend (sum_r),
    .quotient (quot)
  );

  // fault check against the stored average
  assign fault   = (avg_r < bounds.lo) || (avg_r > bounds.hi) || !online;
  assign samp    = fault ? '0 : reading;
  assign avg_eff = fault ? '0 : avg_r;
  assign in_rng  = !strict_gate || ((samp < bounds.hi) && (samp > bounds.lo));

  // old entry at the fill index: forwarded, read, or zero if never written
  assign not_full = (idx_r != FULL);
  assign cur_addr = not_full ? idx_r[AW-1:0] : '0;
  assign old      = hit_r ? fwd_r : (vld_r[cur_addr] ? rd_data_r : '0);

  assign take = not_full && in_rng;
  assign we   = fire && take;

  // read-modify-write of the ring and sum, or the averaging step
  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    avg_nxt = avg_eff;
    if (take) begin
      sum_nxt = sum_r - SW'(old) + SW'(samp);
      idx_nxt = idx_r + 1'b1;
    end else if (!not_full) begin
      avg_nxt = quot;
      idx_nxt = '0;
    end
  end

  // next read goes to the entry the following item will use
  assign ra_idx = fire ? idx_nxt : idx_r;
  assign raddr  = (ra_idx == FULL) ? '0 : ra_idx[AW-1:0];

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      ring_r[cur_addr] <= samp;
    end
    rd_data_r <= ring_r[raddr];
    fwd_r     <= samp;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
      avg_r <= '0;
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      hit_r <= we && (cur_addr == raddr);
      if (we) begin
        vld_r[cur_addr] <= 1'b1;
      end
      if (fire) begin
        idx_r <= idx_nxt;
        sum_r <= sum_nxt;
        avg_r <= avg_nxt;
      end
    end
  end

  assign res.avg   = avg_nxt;
  assign res.fault = fault;

endmodule

[sv/temp_humi_window_average_fault.sv]
// Temperature / humidity block averager with range fault check. Each input item is one tick
// and yields exactly one result item. The block takes one item per clock cycle unless a result
// waits unaccepted: each channel does a read-modify-write of its sample ring memory, with the
// memory read registered ahead at the next fill index and the just-written entry forwarded when
// that read lands on it (a one-entry ring). The result is registered and offered the cycle after
// its item is taken; a new item is taken in the same cycle a waiting result is accepted, so
// items flow back to back when the receiver keeps up. Ring entries never written read as zero
// through per-entry valid bits, so no clearing pass follows reset. Configuration is written
// through cfg_we/cfg_idx/cfg_wdata; the user must write it only while idle, unchecked by the block.
//
// top level; depends on thwa_pkg, thwa_ifs, thwa_chan and thwa_div
module temp_humi_window_average_fault #(
  parameter int unsigned SAMPLE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  thwa_pkg::cfg_idx_t  cfg_idx,
  input  logic [15:0]         cfg_wdata,
  thwa_in_if.sink             in_ch,
  thwa_out_if.source          out_ch
);

  thwa_pkg::bounds_t   temp_bnd_r;
  thwa_pkg::bounds_t   humi_bnd_r;
  thwa_pkg::chan_res_t temp_res;
  thwa_pkg::chan_res_t humi_res;
  thwa_pkg::chval_t    temp_ext;
  thwa_pkg::chval_t    humi_ext;

  logic               fire;
  logic               out_vld_r;
  logic signed [15:0] avg_temp_r;
  logic        [15:0] avg_humi_r;
  logic               temp_fault_r;
  logic               humi_fault_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_bnd_r.lo <= -thwa_pkg::chval_t'(32768);
      temp_bnd_r.hi <= thwa_pkg::chval_t'(32767);
      humi_bnd_r.lo <= '0;
      humi_bnd_r.hi <= thwa_pkg::chval_t'(65535);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        thwa_pkg::CFG_TEMP_MIN: temp_bnd_r.lo <= thwa_pkg::CH_W'(signed'(cfg_wdata));
        thwa_pkg::CFG_TEMP_MAX: temp_bnd_r.hi <= thwa_pkg::CH_W'(signed'(cfg_wdata));
        thwa_pkg::CFG_HUMI_MIN: humi_bnd_r.lo <= {1'b0, cfg_wdata};
        thwa_pkg::CFG_HUMI_MAX: humi_bnd_r.hi <= {1'b0, cfg_wdata};
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  assign temp_ext = thwa_pkg::CH_W'(in_ch.temp_reading);
  assign humi_ext = {1'b0, in_ch.humi_reading};

  // temperature channel, sampled only strictly inside its range
  thwa_chan #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_temp (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .bounds      (temp_bnd_r),
    .reading     (temp_ext),
    .online      (in_ch.link_online),
    .strict_gate (1'b1),
    .res         (temp_res)
  );

  // humidity channel, sampled with no range gate
  thwa_chan #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_humi (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .bounds      (humi_bnd_r),
    .reading     (humi_ext),
    .online      (in_ch.link_online),
    .strict_gate (1'b0),
    .res         (humi_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      avg_temp_r   <= temp_res.avg[15:0];
      temp_fault_r <= temp_res.fault;
      avg_humi_r   <= humi_res.avg[15:0];
      humi_fault_r <= humi_res.fault;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.avg_temp   = avg_temp_r;
  assign out_ch.temp_fault = temp_fault_r;
  assign out_ch.avg_humi   = avg_humi_r;
  assign out_ch.humi_fault = humi_fault_r;

endmodule
